// ----- design/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ELEM_W = 16;   // matrix element and quaternion component width
  localparam int DIFF_W = 17;   // off-diagonal pair sum or difference
  localparam int QBITS  = 15;   // quotient bits kept below the overflow bit

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    branch_t                  br;
    logic                     bad;
    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
  } cls_t;

endpackage

// ----- design/rmq_in_if.sv -----
// ----------------------------------------------------------------------------
// rmq_in_if
// Matrix item channel: valid, ready and the nine Q2.14 elements.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic        valid;
  logic        ready;
  logic signed [rmq_pkg::ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// ----- design/rmq_out_if.sv -----
// ----------------------------------------------------------------------------
// rmq_out_if
// Quaternion item channel: valid, ready and the result fields.
// ----------------------------------------------------------------------------
interface rmq_out_if;
  logic        valid;
  logic        ready;
  logic signed [rmq_pkg::ELEM_W-1:0] quat_x, quat_y, quat_z, quat_w;
  logic [1:0]  branch_taken;
  logic        bad_matrix;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, bad_matrix,
                  input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, bad_matrix,
                  output ready);
endinterface

// ----- design/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the branch, forms the radicand and the pair terms.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 19
) (
  input  logic           clk,
  input  logic           rst,
  rmq_in_if.sink         mat,
  output logic           valid,
  input  logic           ready,
  output rmq_pkg::cls_t  cls,
  output logic [RW-2:0]  rad
);

  localparam int DW = rmq_pkg::DIFF_W;

  logic signed [RW-1:0] a00, a11, a22, one, trace, r;
  logic signed [DW-1:0] b01, b02, b10, b12, b20, b21;
  rmq_pkg::cls_t        cls_next;
  logic                 take;

  assign mat.ready = !valid || ready;
  assign take      = mat.valid && mat.ready;

  always_comb begin
    a00   = RW'(mat.m00);
    a11   = RW'(mat.m11);
    a22   = RW'(mat.m22);
    b01   = DW'(mat.m01);
    b02   = DW'(mat.m02);
    b10   = DW'(mat.m10);
    b12   = DW'(mat.m12);
    b20   = DW'(mat.m20);
    b21   = DW'(mat.m21);
    one   = RW'(1) <<< FRAC_BITS;
    trace = a00 + a11 + a22;
    priority if (trace > 0) begin
      cls_next.br = rmq_pkg::BR_TRACE;
      r           = trace + one;
      cls_next.d0 = b12 - b21;
      cls_next.d1 = b20 - b02;
      cls_next.d2 = b01 - b10;
    end else if (a00 >= a11 && a00 >= a22) begin
      cls_next.br = rmq_pkg::BR_X;
      r           = one + a00 - a11 - a22;
      cls_next.d0 = b01 + b10;
      cls_next.d1 = b20 + b02;
      cls_next.d2 = b12 - b21;
    end else if (a11 >= a22) begin
      cls_next.br = rmq_pkg::BR_Y;
      r           = one + a11 - a00 - a22;
      cls_next.d0 = b01 + b10;
      cls_next.d1 = b12 + b21;
      cls_next.d2 = b20 - b02;
    end else begin
      cls_next.br = rmq_pkg::BR_Z;
      r           = one + a22 - a00 - a11;
      cls_next.d0 = b20 + b02;
      cls_next.d1 = b12 + b21;
      cls_next.d2 = b01 - b10;
    end
    cls_next.bad = (r <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (mat.ready) begin
      valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls <= cls_next;
      rad <= r[RW-2:0];
    end
  end

endmodule

// ----- design/rmq_queue.sv -----
// ----------------------------------------------------------------------------
// rmq_queue
// Two-entry queue between the classifier and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module rmq_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// ----- design/rmq_back.sv -----
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined rounded square root, three restoring dividers, saturation.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int FRAC_BITS = 14,
  parameter int RW        = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           ready,
  input  rmq_pkg::cls_t  cls,
  input  logic [RW-2:0]  rad,
  rmq_out_if.source      quat
);

  localparam int F    = FRAC_BITS;
  localparam int EW   = rmq_pkg::ELEM_W;
  localparam int QB   = rmq_pkg::QBITS;
  localparam int NW   = RW - 1 + F - 2;
  localparam int SW   = (NW + 1) / 2;
  localparam int NW2  = 2 * SW;
  localparam int BW   = SW + 1;
  localparam int DVW  = BW + 3;
  localparam int NUMW = (((F + 18) > (BW + 2)) ? (F + 18) : (BW + 2)) + 1;
  localparam int DW   = ((NUMW > (DVW + QB)) ? NUMW : (DVW + QB)) + 1;
  localparam int DS   = QB + 1;

  logic adv;
  assign adv   = !quat.valid || quat.ready;
  assign ready = adv;

  // square root stages, one result bit each
  logic                s_v    [SW];
  logic [NW2-1:0]      s_n    [SW];
  logic [SW+1:0]       s_rem  [SW];
  logic [SW-1:0]       s_root [SW];
  rmq_pkg::cls_t       s_cls  [SW];
  logic [NW2-1:0]      x_n    [SW];
  logic [SW+1:0]       x_rem  [SW];
  logic [SW-1:0]       x_root [SW];

  always_comb begin
    logic [NW2-1:0] sn;
    logic [SW+1:0]  sr, remx, trial;
    logic [SW-1:0]  so;
    for (int k = 0; k < SW; k++) begin
      if (k == 0) begin
        sn = NW2'({rad, {(F-2){1'b0}}});
        sr = '0;
        so = '0;
      end else begin
        sn = s_n[k-1];
        sr = s_rem[k-1];
        so = s_root[k-1];
      end
      remx  = {sr[SW-1:0], sn[NW2-1 -: 2]};
      trial = {so, 2'b01};
      if (remx >= trial) begin
        x_rem[k]  = remx - trial;
        x_root[k] = {so[SW-2:0], 1'b1};
      end else begin
        x_rem[k]  = remx;
        x_root[k] = {so[SW-2:0], 1'b0};
      end
      x_n[k] = sn << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SW; k++) s_v[k] <= 1'b0;
    end else if (adv) begin
      s_v[0] <= valid;
      for (int k = 1; k < SW; k++) s_v[k] <= s_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < SW; k++) begin
        s_n[k]    <= x_n[k];
        s_rem[k]  <= x_rem[k];
        s_root[k] <= x_root[k];
        s_cls[k]  <= (k == 0) ? cls : s_cls[k-1];
      end
    end
  end

  // rounding and divider setup: num = mag*2^(F+1) + 4*big, divisor 8*big
  logic                u_v;
  rmq_pkg::cls_t       u_cls;
  logic [BW-1:0]       u_big;
  logic [DVW-1:0]      u_div;
  logic [NUMW-1:0]     u_num [3];
  logic                u_neg [3];
  logic [BW-1:0]       big;
  logic signed [rmq_pkg::DIFF_W-1:0] dl [3];

  always_comb begin
    big   = BW'(s_root[SW-1]) +
            BW'(s_rem[SW-1] > (SW+2)'(s_root[SW-1]));
    dl[0] = s_cls[SW-1].d0;
    dl[1] = s_cls[SW-1].d1;
    dl[2] = s_cls[SW-1].d2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u_v <= 1'b0;
    end else if (adv) begin
      u_v <= s_v[SW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_cls <= s_cls[SW-1];
      u_big <= big;
      u_div <= {big, 3'b000};
      for (int l = 0; l < 3; l++) begin
        u_neg[l] <= dl[l][rmq_pkg::DIFF_W-1];
        u_num[l] <= NUMW'({(dl[l][rmq_pkg::DIFF_W-1] ? 17'(-dl[l]) : 17'(dl[l])),
                           {(F+1){1'b0}}}) + NUMW'({big, 2'b00});
      end
    end
  end

  // divider stages: first the overflow test, then one quotient bit each
  logic                d_v   [DS];
  rmq_pkg::cls_t       d_cls [DS];
  logic [BW-1:0]       d_big [DS];
  logic [DVW-1:0]      d_div [DS];
  logic [NUMW-1:0]     d_rem [DS][3];
  logic [QB-1:0]       d_q   [DS][3];
  logic                d_ovf [DS][3];
  logic                d_neg [DS][3];
  logic [NUMW-1:0]     y_rem [DS][3];
  logic [QB-1:0]       y_q   [DS][3];
  logic                y_ovf [DS][3];

  always_comb begin
    logic [DVW-1:0]  dv;
    logic [NUMW-1:0] rm;
    logic [QB-1:0]   qq;
    logic            ov;
    logic [DW-1:0]   t;
    for (int j = 0; j < DS; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          dv = u_div;
          rm = u_num[l];
          qq = '0;
          ov = 1'b0;
        end else begin
          dv = d_div[j-1];
          rm = d_rem[j-1][l];
          qq = d_q[j-1][l];
          ov = d_ovf[j-1][l];
        end
        t = DW'(dv) << (QB - j);
        y_rem[j][l] = rm;
        y_q[j][l]   = qq;
        y_ovf[j][l] = ov;
        if (DW'(rm) >= t) begin
          if (j == 0) begin
            y_ovf[j][l] = 1'b1;
          end else begin
            y_rem[j][l]        = NUMW'(DW'(rm) - t);
            y_q[j][l][QB - j]  = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < DS; j++) d_v[j] <= 1'b0;
    end else if (adv) begin
      d_v[0] <= u_v;
      for (int j = 1; j < DS; j++) d_v[j] <= d_v[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < DS; j++) begin
        d_cls[j] <= (j == 0) ? u_cls : d_cls[j-1];
        d_big[j] <= (j == 0) ? u_big : d_big[j-1];
        d_div[j] <= (j == 0) ? u_div : d_div[j-1];
        for (int l = 0; l < 3; l++) begin
          d_rem[j][l] <= y_rem[j][l];
          d_q[j][l]   <= y_q[j][l];
          d_ovf[j][l] <= y_ovf[j][l];
          d_neg[j][l] <= (j == 0) ? u_neg[l] : d_neg[j-1][l];
        end
      end
    end
  end

  // saturation and component placement
  function automatic logic signed [EW-1:0] lane_val(logic [QB-1:0] q, logic ovf,
                                                    logic neg);
    logic signed [EW-1:0] v;
    if (ovf) v = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    else     v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return v;
  endfunction

  logic signed [EW-1:0] c [3];
  logic signed [EW-1:0] bs;
  logic signed [EW-1:0] qx, qy, qz, qw;
  rmq_pkg::cls_t        lc;

  always_comb begin
    lc = d_cls[DS-1];
    for (int l = 0; l < 3; l++) c[l] = lane_val(d_q[DS-1][l], d_ovf[DS-1][l], d_neg[DS-1][l]);
    if (d_big[DS-1] > BW'(2**(EW-1) - 1)) bs = {1'b0, {(EW-1){1'b1}}};
    else bs = $signed(EW'(d_big[DS-1]));
    unique case (lc.br)
      rmq_pkg::BR_TRACE: begin qx = c[0]; qy = c[1]; qz = c[2]; qw = bs;   end
      rmq_pkg::BR_X:     begin qx = bs;   qy = c[0]; qz = c[1]; qw = c[2]; end
      rmq_pkg::BR_Y:     begin qx = c[0]; qy = bs;   qz = c[1]; qw = c[2]; end
      rmq_pkg::BR_Z:     begin qx = c[0]; qy = c[1]; qz = bs;   qw = c[2]; end
      default:           begin qx = '0;   qy = '0;   qz = '0;   qw = '0;   end
    endcase
    if (lc.bad) begin
      qx = '0; qy = '0; qz = '0; qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.valid <= 1'b0;
    end else if (adv) begin
      quat.valid <= d_v[DS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat.quat_x       <= qx;
      quat.quat_y       <= qy;
      quat.quat_z       <= qz;
      quat.quat_w       <= qw;
      quat.branch_taken <= lc.br;
      quat.bad_matrix   <= lc.bad;
    end
  end

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// An item passes the front register, the queue, the square root stages, the
// rounding stage, the divider stages and the output register. One item is taken
// per cycle unless the output stalls. Square root: one bit per stage; dividers:
// one quotient bit per stage; a two-entry queue decouples classifier and pipeline.
// Reset: synchronous, active high; clears all valid flags and the queue.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix in Q2.14 to unit quaternion, trace-branch method.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst,
  rmq_in_if.sink    mat,
  rmq_out_if.source quat
);

  localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int QW = $bits(rmq_pkg::cls_t) + RW - 1;

  logic              f_valid, f_ready, b_valid, b_ready;
  rmq_pkg::cls_t     f_cls, b_cls;
  logic [RW-2:0]     f_rad, b_rad;
  logic [QW-1:0]     q_out;

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .clk   (clk),
    .rst   (rst),
    .mat   (mat),
    .valid (f_valid),
    .ready (f_ready),
    .cls   (f_cls),
    .rad   (f_rad)
  );

  rmq_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_cls, f_rad}),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  assign b_cls = q_out[QW-1 -: $bits(rmq_pkg::cls_t)];
  assign b_rad = q_out[RW-2:0];

  rmq_back #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_back (
    .clk   (clk),
    .rst   (rst),
    .valid (b_valid),
    .ready (b_ready),
    .cls   (b_cls),
    .rad   (b_rad),
    .quat  (quat)
  );

endmodule
